// ----- design/tsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and the time scale table for the time scale
// converter.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int W           = 64;
  localparam int ROWS        = 9;
  localparam int COLS        = 11;
  localparam int NCELL       = 64;
  localparam int SCALE_COUNT_DEF = 9;

  typedef logic signed [W-1:0] word_t;

  // Opcodes.
  localparam logic [1:0] OP_TO_UNIV   = 2'd0;
  localparam logic [1:0] OP_FROM_UNIV = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  // Table columns.
  localparam logic [3:0] COL_UNITS = 4'd0;
  localparam logic [3:0] COL_OFF   = 4'd1;
  localparam logic [3:0] COL_FMIN  = 4'd2;
  localparam logic [3:0] COL_FMAX  = 4'd3;
  localparam logic [3:0] COL_TMIN  = 4'd4;
  localparam logic [3:0] COL_TMAX  = 4'd5;
  localparam logic [3:0] COL_OFFP1 = 4'd6;
  localparam logic [3:0] COL_OFFM1 = 4'd7;
  localparam logic [3:0] COL_RND   = 4'd8;
  localparam logic [3:0] COL_MINR  = 4'd9;
  localparam logic [3:0] COL_MAXR  = 4'd10;

  localparam word_t I64MIN = 64'sh8000_0000_0000_0000;
  localparam word_t I64MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_MUL,
    MODE_DIV
  } mode_t;

  // One row of the scale table.
  typedef struct packed {
    word_t units;
    word_t off;
    word_t fmin;
    word_t fmax;
    word_t tmin;
    word_t tmax;
    word_t offp1;
    word_t offm1;
    word_t rnd;
    word_t minr;
    word_t maxr;
  } scale_row_t;

  // Beat state carried along the cell chain.
  typedef struct packed {
    logic  vld;
    logic  err;
    mode_t mode;
    logic  neg;
    word_t off;
    word_t units;
    word_t acc;
    word_t x;
  } cell_t;

  function automatic scale_row_t get_row(input logic [3:0] r);
    scale_row_t row;
    row = '0;
    unique case (r)
      4'd0, 4'd2: begin
        row = '{64'sd10000, 64'sd62135769600000, -64'sd984472973285477,
                64'sd860201434085477, -64'sd9223372036854774999,
                64'sd9223372036854774999, 64'sd62135769600001,
                64'sd62135769599999, 64'sd5000, -64'sd9223372036854770808,
                64'sd9223372036854770807};
      end
      4'd1: begin
        row = '{64'sd10000000, 64'sd62135769600, -64'sd984472973285,
                64'sd860201434085, I64MIN, I64MAX, 64'sd62135769601,
                64'sd62135769599, 64'sd5000000, -64'sd9223372036849775808,
                64'sd9223372036849775807};
      end
      4'd3: begin
        row = '{64'sd1, 64'sd504912960000000000, I64MIN,
                64'sd8718459076854775807, -64'sd8718459076854775808, I64MAX,
                64'sd504912960000000000, 64'sd504912960000000000, 64'sd0,
                I64MIN, I64MAX};
      end
      4'd4: begin
        row = '{64'sd1, 64'sd0, I64MIN, I64MAX, I64MIN, I64MAX, 64'sd0,
                64'sd0, 64'sd0, I64MIN, I64MAX};
      end
      4'd5: begin
        row = '{64'sd10000000, 64'sd60052924800, -64'sd982390128485,
                64'sd862284278885, I64MIN, I64MAX, 64'sd60052924801,
                64'sd60052924799, 64'sd5000000, -64'sd9223372036849775808,
                64'sd9223372036849775807};
      end
      4'd6: begin
        row = '{64'sd10000000, 64'sd63114076800, -64'sd985451280485,
                64'sd859223126885, I64MIN, I64MAX, 64'sd63114076801,
                64'sd63114076799, 64'sd5000000, -64'sd9223372036849775808,
                64'sd9223372036849775807};
      end
      4'd7, 4'd8: begin
        row = '{64'sd864000000000, 64'sd693596, -64'sd11368795, 64'sd9981603,
                I64MIN, I64MAX, 64'sd693597, 64'sd693595, 64'sd432000000000,
                -64'sd9223371604854775808, 64'sd9223371604854775807};
      end
      default: begin
        row = '0;
      end
    endcase
    return row;
  endfunction

  function automatic word_t get_col(input scale_row_t row, input logic [3:0] c);
    word_t v;
    v = '0;
    unique case (c)
      COL_UNITS: v = row.units;
      COL_OFF:   v = row.off;
      COL_FMIN:  v = row.fmin;
      COL_FMAX:  v = row.fmax;
      COL_TMIN:  v = row.tmin;
      COL_TMAX:  v = row.tmax;
      COL_OFFP1: v = row.offp1;
      COL_OFFM1: v = row.offm1;
      COL_RND:   v = row.rnd;
      COL_MINR:  v = row.minr;
      COL_MAXR:  v = row.maxr;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/tsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_front
// Table lookup, range check and rounding adjust, then sign split of the
// operand, in two register stages ahead of the cell chain.
// ----------------------------------------------------------------------------
module tsc_front import tsc_pkg::*; #(
  parameter int SCALE_COUNT = SCALE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] time_in,
  input  wire logic [3:0]  scale_index,
  input  wire logic [3:0]  column_index,
  output cell_t            dout
);

  // First stage registers.
  logic  vld1;
  logic  err1;
  mode_t mode1;
  word_t a1;
  word_t off1;
  word_t units1;

  logic       err_c;
  mode_t      mode_c;
  word_t      a_c;
  word_t      off_c;
  word_t      t;
  scale_row_t row;
  logic       sc_ok;

  // Decode, range check and select the rounding form.
  always_comb begin
    t      = word_t'(time_in);
    row    = get_row(scale_index);
    sc_ok  = (32'(scale_index) < SCALE_COUNT) && (32'(scale_index) < ROWS);
    err_c  = 1'b0;
    mode_c = MODE_PASS;
    a_c    = '0;
    off_c  = '0;
    if (!sc_ok) begin
      err_c = 1'b1;
    end else begin
      unique case (opcode)
        OP_TO_UNIV: begin
          if (t < row.fmin || t > row.fmax) begin
            err_c = 1'b1;
          end else begin
            mode_c = MODE_MUL;
            a_c    = t + row.off;
          end
        end
        OP_FROM_UNIV: begin
          if (t < row.tmin || t > row.tmax) begin
            err_c = 1'b1;
          end else begin
            mode_c = MODE_DIV;
            if (t < 0) begin
              if (t < row.minr) begin
                a_c   = t + row.rnd;
                off_c = row.offp1;
              end else begin
                a_c   = t - row.rnd;
                off_c = row.off;
              end
            end else if (t > row.maxr) begin
              a_c   = t - row.rnd;
              off_c = row.offm1;
            end else begin
              a_c   = t + row.rnd;
              off_c = row.off;
            end
          end
        end
        OP_READ: begin
          if (column_index >= 4'(COLS)) begin
            err_c = 1'b1;
          end else begin
            a_c = get_col(row, column_index);
          end
        end
        default: begin
          err_c = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    err1   <= err_c;
    mode1  <= mode_c;
    a1     <= a_c;
    off1   <= off_c;
    units1 <= row.units;
  end

  // Second stage: load the chain, dividing on the magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= vld1;
    end
    dout.err   <= err1;
    dout.mode  <= mode1;
    dout.off   <= off1;
    dout.units <= units1;
    dout.neg   <= (mode1 == MODE_DIV) && (a1 < 0);
    if (mode1 == MODE_PASS) begin
      dout.acc <= err1 ? '0 : a1;
      dout.x   <= '0;
    end else if (mode1 == MODE_DIV) begin
      dout.acc <= '0;
      dout.x   <= (a1 < 0) ? -a1 : a1;
    end else begin
      dout.acc <= '0;
      dout.x   <= a1;
    end
  end

endmodule
`default_nettype wire

// ----- design/tsc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_cell
// One step of the chain: a shift-add multiply step on multiplier bit IDX, or
// one restoring divide step that produces one quotient bit.
// ----------------------------------------------------------------------------
module tsc_cell import tsc_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cell_t din,
  output cell_t      dout
);

  localparam int IW = $clog2(W);

  logic [W:0]   rs;
  logic         ge;
  logic [W-1:0] acc_next;
  logic [W-1:0] x_next;

  // Step arithmetic for the current beat.
  always_comb begin
    rs       = {din.acc, din.x[W-1]};
    ge       = rs >= {1'b0, din.units};
    acc_next = din.acc;
    x_next   = din.x;
    unique case (din.mode)
      MODE_MUL: begin
        if (din.units[IW'(IDX)]) begin
          acc_next = din.acc + (din.x << IDX);
        end
      end
      MODE_DIV: begin
        acc_next = ge ? W'(rs - {1'b0, din.units}) : rs[W-1:0];
        x_next   = {din.x[W-2:0], ge};
      end
      default: begin
        acc_next = din.acc;
      end
    endcase
  end

  // Hand the beat to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.err   <= din.err;
    dout.mode  <= din.mode;
    dout.neg   <= din.neg;
    dout.off   <= din.off;
    dout.units <= din.units;
    dout.acc   <= acc_next;
    dout.x     <= x_next;
  end

endmodule
`default_nettype wire

// ----- design/time_scale_converter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_scale_converter_top
// An accepted beat passes through two front stages, 64 chain cells and one
// output register before its result is taken.
// Throughput: one beat per cycle; busy is low except during reset.
// Reset clears all valid flags; no clearing pass is needed. The receiver
// cannot stall the result, so the chain never holds.
// ----------------------------------------------------------------------------
module time_scale_converter_top import tsc_pkg::*; #(
  parameter int SCALE_COUNT = SCALE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] time_in,
  input  wire logic [3:0]  scale_index,
  input  wire logic [3:0]  column_index,
  output logic             done,
  output logic [63:0]      result,
  output logic             error
);

  localparam int Latency = NCELL + 3;

  cell_t chain [NCELL+1];
  logic  accept;
  word_t q;

  assign busy   = rst;
  assign accept = start && !busy;

  // Front stages.
  tsc_front #(
    .SCALE_COUNT(SCALE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .time_in     (time_in),
    .scale_index (scale_index),
    .column_index(column_index),
    .dout        (chain[0])
  );

  // Row of multiply and divide cells.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    tsc_cell #(
      .IDX(i)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  // Restore the quotient sign and take off the epoch offset.
  always_comb begin
    q = chain[NCELL].neg ? ~chain[NCELL].x : chain[NCELL].x;
    q = q - chain[NCELL].off + word_t'(chain[NCELL].neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[NCELL].vld;
    end
  end

  always_ff @(posedge clk) begin
    error  <= chain[NCELL].err;
    result <= (chain[NCELL].mode == MODE_DIV) ? q : chain[NCELL].acc;
  end

  // A rejected request always reads as zero.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && error |-> result == 64'd0)
    else $error("error beat with nonzero result");

  // Every result beat goes back to one accepted beat.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, Latency))
    else $error("result beat without a matching input beat");

  // An unused opcode is flagged.
  a_bad_op: assert property (@(posedge clk) disable iff (rst)
    accept && opcode != OP_TO_UNIV && opcode != OP_FROM_UNIV && opcode != OP_READ
    |-> ##Latency (done && error))
    else $error("unused opcode not flagged");

endmodule
`default_nettype wire
